/* hw/rtl/rotated_block_copy_engine_defines.svh */
// Assertion macros shared by the rotated block copy engine RTL.
// Depends on nothing; files that assert include it by its bare name.
// The macros expect a clock named clk and an active-low reset named rst_n.
`ifndef ROTATED_BLOCK_COPY_ENGINE_DEFINES_SVH
`define ROTATED_BLOCK_COPY_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBC_ASSERT(lbl, prop, msg)
`define RBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/rbc_pkg.sv */
// Shared constants, codes and types of the rotated block copy engine.
// Depends on nothing; every module of the block imports it.
package rbc_pkg;

  localparam int ROWS       = 32;
  localparam int COLS       = 32;
  localparam int PIXEL_BITS = 8;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths of the item and result channels.
  localparam int CRD_W    = 5;
  localparam int SIDE_W   = 6;
  localparam int IN_PIX_W = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_PIX_W   = 8;
  localparam int CNT_W       = 11;
  localparam int OUT_TDATA_W = 24;

  // Width used for bound checks and coordinate sums.
  localparam int CHK_W = 10;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_BLIT  = 2'd2;

  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_R90  = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_L90  = 2'd3;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_BLIT,
    CMD_NONE,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       dst_row;
    logic [COL_W-1:0]       dst_col;
    logic [SIDE_W-1:0]      h;
    logic [SIDE_W-1:0]      w;
    logic [1:0]             rotation;
    logic [PIXEL_BITS-1:0]  pixel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic vld;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD,
    B_WR
  } back_state_t;

endpackage

/* hw/rtl/rbc_front.sv */
// Front end: unpacks an input item, checks it against the frame and turns it
// into a command for the queue. Depends on rbc_pkg.
module rbc_front
  import rbc_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  q_status_t             q_stat,
  output logic                  push,
  output cmd_t                  push_cmd
);

  logic [CRD_W-1:0]    row, col, dst_row, dst_col;
  logic [SIDE_W-1:0]   height, width, w_eff;
  logic [1:0]          rotation;
  logic [IN_PIX_W-1:0] pixel;
  logic                in_frame, src_fits, dst_fits, empty;

  assign row      = in_tdata[4:0];
  assign col      = in_tdata[9:5];
  assign dst_row  = in_tdata[14:10];
  assign dst_col  = in_tdata[19:15];
  assign height   = in_tdata[25:20];
  assign width    = in_tdata[31:26];
  assign rotation = in_tdata[33:32];
  assign pixel    = in_tdata[41:34];

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  // Rotated blocks are square, with the height as the side.
  assign w_eff = (rotation == ROT_NONE) ? width : height;

  assign in_frame = (CHK_W'(row) < CHK_W'(ROWS)) && (CHK_W'(col) < CHK_W'(COLS));
  assign src_fits = (CHK_W'(row) + CHK_W'(height) <= CHK_W'(ROWS)) &&
                    (CHK_W'(col) + CHK_W'(w_eff) <= CHK_W'(COLS));
  assign dst_fits = (CHK_W'(dst_row) + CHK_W'(height) <= CHK_W'(ROWS)) &&
                    (CHK_W'(dst_col) + CHK_W'(w_eff) <= CHK_W'(COLS));
  assign empty    = (height == '0) || (w_eff == '0);

  always_comb begin
    push_cmd          = '0;
    push_cmd.row      = ROW_W'(row);
    push_cmd.col      = COL_W'(col);
    push_cmd.dst_row  = ROW_W'(dst_row);
    push_cmd.dst_col  = COL_W'(dst_col);
    push_cmd.h        = height;
    push_cmd.w        = w_eff;
    push_cmd.pixel    = PIXEL_BITS'(pixel);
    // Single-pixel commands reuse the unrotated source address path.
    push_cmd.rotation = (in_tuser == ACT_BLIT) ? rotation : ROT_NONE;
    unique case (in_tuser)
      ACT_WRITE: push_cmd.kind = in_frame ? CMD_WRITE : CMD_ERROR;
      ACT_READ:  push_cmd.kind = in_frame ? CMD_READ : CMD_ERROR;
      ACT_BLIT: begin
        if (!(src_fits && dst_fits)) begin
          push_cmd.kind = CMD_ERROR;
        end else if (empty) begin
          push_cmd.kind = CMD_NONE;
        end else begin
          push_cmd.kind = CMD_BLIT;
        end
      end
      default:   push_cmd.kind = CMD_ERROR;
    endcase
  end

endmodule

/* hw/rtl/rbc_queue.sv */
// Short command queue between the front end and the back end.
// Depends on rbc_pkg and the assertion macro header.
`include "rotated_block_copy_engine_defines.svh"
module rbc_queue
  import rbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t q_stat
);

  cmd_t            ent_r [Q_DEPTH];
  logic [QP_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full = (cnt_r == QC_W'(Q_DEPTH));
  assign q_stat.vld  = (cnt_r != '0);
  assign head_cmd    = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QP_W'(Q_DEPTH - 1)) ? '0 : wp_r + QP_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == QP_W'(Q_DEPTH - 1)) ? '0 : rp_r + QP_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  `RBC_ASSERT(a_q_cnt_bound, cnt_r <= QC_W'(Q_DEPTH), "queue count above depth")
  `RBC_ASSERT(a_q_grow, push && !pop |=> cnt_r == $past(cnt_r) + QC_W'(1), "queue grow")
  `RBC_ASSERT(a_q_shrink, pop && !push |=> cnt_r == $past(cnt_r) - QC_W'(1), "queue shrink")

endmodule

/* hw/rtl/rbc_back.sv */
// Back end: runs queued commands against the frame store and holds the result
// item in an output register. Depends on rbc_pkg and the assertion macro header.
`include "rotated_block_copy_engine_defines.svh"
module rbc_back
  import rbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_status_t              q_stat,
  input  cmd_t                   head_cmd,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  function automatic logic [ADDR_W-1:0] addr_of(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;
  logic [SIDE_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_new;
  logic              out_vld_r;
  logic [OUT_PIX_W-1:0] rd_pix_r, res_pix;
  logic [CNT_W-1:0]     res_cnt_r, res_cnt;
  logic                 status_r, res_status;
  logic                 res_load;

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] src_q_r, dst_q_r, mem_wd;
  logic [ADDR_W-1:0]     src_addr, dst_addr, mem_wa;
  logic                  rd_en, mem_we;

  logic [CHK_W-1:0] r0, c0, hh, ii, jj, sr, sc;

  // Source coordinate of destination offset (i, j) for each rotation.
  always_comb begin
    r0 = CHK_W'(cmd_r.row);
    c0 = CHK_W'(cmd_r.col);
    hh = CHK_W'(cmd_r.h);
    ii = CHK_W'(i_r);
    jj = CHK_W'(j_r);
    case (cmd_r.rotation)
      ROT_R90: begin
        sr = r0 + hh - CHK_W'(1) - jj;
        sc = c0 + ii;
      end
      ROT_180: begin
        sr = r0 + hh - CHK_W'(1) - ii;
        sc = c0 + hh - CHK_W'(1) - jj;
      end
      ROT_L90: begin
        sr = r0 + jj;
        sc = c0 + hh - CHK_W'(1) - ii;
      end
      default: begin
        sr = r0 + ii;
        sc = c0 + jj;
      end
    endcase
  end

  assign src_addr = addr_of(ROW_W'(sr), COL_W'(sc));
  assign dst_addr = addr_of(ROW_W'(CHK_W'(cmd_r.dst_row) + ii),
                            COL_W'(CHK_W'(cmd_r.dst_col) + jj));

  assign cnt_new = ((src_q_r != dst_q_r) && (cnt_r != COUNT_MAX)) ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cnt_nxt    = cnt_r;
    pop        = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = src_addr;
    mem_wd     = cmd_r.pixel;
    res_load   = 1'b0;
    res_pix    = '0;
    res_cnt    = '0;
    res_status = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_stat.vld && !out_vld_r) begin
          pop       = 1'b1;
          i_nxt     = '0;
          j_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        unique case (cmd_r.kind) inside
          CMD_WRITE: begin
            mem_we    = 1'b1;
            res_load  = 1'b1;
            state_nxt = B_IDLE;
          end
          CMD_READ, CMD_BLIT: begin
            rd_en     = 1'b1;
            state_nxt = B_WR;
          end
          CMD_NONE: begin
            res_load  = 1'b1;
            state_nxt = B_IDLE;
          end
          default: begin
            res_load   = 1'b1;
            res_status = 1'b1;
            state_nxt  = B_IDLE;
          end
        endcase
      end
      B_WR: begin
        if (cmd_r.kind == CMD_READ) begin
          res_load  = 1'b1;
          res_pix   = OUT_PIX_W'(src_q_r);
          state_nxt = B_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = dst_addr;
          mem_wd    = src_q_r;
          cnt_nxt   = cnt_new;
          state_nxt = B_RD;
          if (j_r == cmd_r.w - SIDE_W'(1)) begin
            j_nxt = '0;
            if (i_r == cmd_r.h - SIDE_W'(1)) begin
              res_load  = 1'b1;
              res_cnt   = cnt_new;
              state_nxt = B_IDLE;
            end else begin
              i_nxt = i_r + SIDE_W'(1);
            end
          end else begin
            j_nxt = j_r + SIDE_W'(1);
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cnt_r <= cnt_nxt;
    if (res_load) begin
      rd_pix_r  <= res_pix;
      res_cnt_r <= res_cnt;
      status_r  <= res_status;
    end
  end

  // Frame store: one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      src_q_r <= mem[src_addr];
      dst_q_r <= mem[dst_addr];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - CNT_W - OUT_PIX_W)'(0), res_cnt_r, rd_pix_r};
  assign out_tuser  = status_r;

  `RBC_ASSERT(a_no_overwrite, res_load |-> !out_vld_r, "result loaded over a pending item")
  `RBC_ASSERT(a_rise_from_work, $rose(out_vld_r) |-> $past(state_r) != B_IDLE,
              "result appeared without a command")
  `RBC_ASSERT(a_blit_bounds,
              (state_r == B_WR) && (cmd_r.kind == CMD_BLIT) |-> (i_r < cmd_r.h) && (j_r < cmd_r.w),
              "blit offset outside block")

endmodule

/* hw/rtl/rotated_block_copy_engine.sv */
// Rotated block copy engine top level: front end, command queue, back end.
// An accepted item is written into the queue; the back end pops it into its command
// register and runs it: a write, an empty or a rejected item loads the result in the
// read state, a read reads the frame store and then loads the result, and a blit reads
// source and destination and then writes, once per destination pixel. The back end starts
// a command only once the previous result is taken. Two commands queue.
// Reset clears the control state; the frame store is not cleared and holds
// undefined data until written.
module rotated_block_copy_engine
  import rbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: row[4:0], col[9:5], dst_row[14:10], dst_col[19:15],
  // height[25:20], width[31:26], rotation[33:32], pixel[41:34], zeros above.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: action[1:0].
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: read_pixel[7:0], changed_count[18:8], zeros above.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Fields from bit 0: status[0].
  output logic                   out_tuser
);

  q_status_t q_stat;
  logic      push, pop;
  cmd_t      push_cmd, head_cmd;

  rbc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  rbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
